/* sv/i2cbs_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the I2C master bit sequencer.
// Used by the front end, the command queue and the sequencer back end.
package i2cbs_pkg;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_STOP  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   localparam int HOLD_W = 16;
   localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd250;

   localparam int STEP_W = 5;

   // Index of the final pin event of each command.
   localparam logic [STEP_W-1:0] LAST_START = 5'd3;
   localparam logic [STEP_W-1:0] LAST_STOP  = 5'd2;
   localparam logic [STEP_W-1:0] LAST_WRITE = 5'd26;
   localparam logic [STEP_W-1:0] LAST_READ  = 5'd20;

   // First event of the acknowledge clock.
   localparam logic [STEP_W-1:0] WRITE_ACK_STEP = 5'd24;
   localparam logic [STEP_W-1:0] READ_ACK_STEP  = 5'd17;

   // Phases of one write bit clock.
   localparam logic [1:0] PH_SETUP = 2'd0;
   localparam logic [1:0] PH_HIGH  = 2'd1;
   localparam logic [1:0] PH_LOW   = 2'd2;

   // A command as classified by the front end.
   typedef struct packed {
      logic [1:0]        op;
      logic [7:0]        data;      // byte to send, or byte the slave shows
      logic              lvl;       // sampled ACK on a write, driven level on a read
      logic [STEP_W-1:0] last_step;
   } cmd_type;

endpackage

/* sv/i2cbs_front.sv */
`timescale 1ns / 1ps
// Front end: accepts command beats and classifies them into queue entries.
// Depends on i2cbs_pkg.
module i2cbs_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_operation,
   input  logic [7:0]       req_write_data,
   input  logic             req_send_ack,
   input  logic [7:0]       req_slave_byte,
   input  logic             req_slave_ack_level,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output i2cbs_pkg::cmd_type cmd_data
);

   logic                valid_ff, valid_in;
   i2cbs_pkg::cmd_type  cmd_ff, cmd_in;
   logic                take;

   assign req_ready = !valid_ff || cmd_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      cmd_in.op = req_operation;
      if (req_operation == i2cbs_pkg::OP_WRITE) begin
         cmd_in.data = req_write_data;
         cmd_in.lvl  = req_slave_ack_level;
      end else begin
         cmd_in.data = req_slave_byte;
         cmd_in.lvl  = !req_send_ack;
      end
      case (req_operation)
         i2cbs_pkg::OP_START: cmd_in.last_step = i2cbs_pkg::LAST_START;
         i2cbs_pkg::OP_STOP:  cmd_in.last_step = i2cbs_pkg::LAST_STOP;
         i2cbs_pkg::OP_WRITE: cmd_in.last_step = i2cbs_pkg::LAST_WRITE;
         default:             cmd_in.last_step = i2cbs_pkg::LAST_READ;
      endcase
   end

   assign valid_in = take ? 1'b1 : (cmd_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd_valid = valid_ff;
   assign cmd_data  = cmd_ff;

endmodule

/* sv/i2cbs_fifo.sv */
`timescale 1ns / 1ps
// Two-entry command queue between the front end and the sequencer.
// Depends on i2cbs_pkg.
module i2cbs_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  i2cbs_pkg::cmd_type push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output i2cbs_pkg::cmd_type pop_data
);

   i2cbs_pkg::cmd_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* sv/i2cbs_back.sv */
`timescale 1ns / 1ps
// Back end: steps through the pin events of one command, times the holds
// and registers each event as a result beat. Depends on i2cbs_pkg.
module i2cbs_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data,
   input  logic               cmd_valid,
   output logic               cmd_ready,
   input  i2cbs_pkg::cmd_type cmd_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_scl_level,
   output logic               rsp_sda_level,
   output logic               rsp_hold_after,
   output logic               rsp_last,
   output logic [7:0]         rsp_read_data,
   output logic               rsp_ack_level
);

   logic [i2cbs_pkg::HOLD_W-1:0] hold_cycles_ff, hold_cycles_in;
   logic [i2cbs_pkg::HOLD_W-1:0] wait_ff, wait_in;
   logic                         busy_ff, busy_in;
   i2cbs_pkg::cmd_type           cur_ff, cur_in;
   logic [i2cbs_pkg::STEP_W-1:0] step_ff, step_in;
   logic [1:0]                   phase_ff, phase_in;
   logic [7:0]                   shift_ff, shift_in;
   logic                         scl_line_ff, scl_line_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         scl_ff, sda_ff, hold_ff, last_ff, ack_ff;
   logic [7:0]                   rdata_ff;

   logic       ev_scl, ev_sda, ev_hold, ev_last, ev_ack;
   logic [7:0] ev_rdata;
   logic       emit, load;

   // Pin event for the current step of the current command.
   always_comb begin
      ev_scl   = 1'b0;
      ev_sda   = 1'b1;
      ev_hold  = 1'b0;
      ev_last  = (step_ff == cur_ff.last_step);
      ev_ack   = 1'b0;
      ev_rdata = 8'd0;
      case (cur_ff.op)
         i2cbs_pkg::OP_START: begin
            case (step_ff)
               5'd0: begin ev_scl = scl_line_ff; ev_sda = 1'b1; end
               5'd1: begin ev_scl = 1'b1; ev_sda = 1'b1; ev_hold = 1'b1; end
               5'd2: begin ev_scl = 1'b1; ev_sda = 1'b0; ev_hold = 1'b1; end
               default: begin ev_scl = 1'b0; ev_sda = 1'b0; end
            endcase
         end
         i2cbs_pkg::OP_STOP: begin
            case (step_ff)
               5'd0: begin ev_scl = scl_line_ff; ev_sda = 1'b0; end
               5'd1: begin ev_scl = 1'b1; ev_sda = 1'b0; ev_hold = 1'b1; end
               default: begin ev_scl = 1'b1; ev_sda = 1'b1; ev_hold = 1'b1; end
            endcase
         end
         i2cbs_pkg::OP_WRITE: begin
            // The acknowledge clock releases SDA so the slave can acknowledge.
            ev_sda = (step_ff >= i2cbs_pkg::WRITE_ACK_STEP) ? 1'b1 : shift_ff[7];
            case (phase_ff)
               i2cbs_pkg::PH_SETUP: ev_scl = scl_line_ff;
               i2cbs_pkg::PH_HIGH:  begin ev_scl = 1'b1; ev_hold = 1'b1; end
               default:             ev_scl = 1'b0;
            endcase
            ev_ack = ev_last ? cur_ff.lvl : 1'b0;
         end
         default: begin
            if (step_ff == 5'd0) begin
               ev_scl = scl_line_ff;
            end else if (step_ff < i2cbs_pkg::READ_ACK_STEP) begin
               // Odd steps raise SCL for a sample, even steps lower it.
               ev_scl  = step_ff[0];
               ev_hold = step_ff[0];
            end else if (ev_last) begin
               ev_scl   = 1'b0;
               ev_rdata = cur_ff.data;
            end else begin
               ev_sda  = cur_ff.lvl;
               ev_scl  = (step_ff == i2cbs_pkg::READ_ACK_STEP + 5'd1);
               ev_hold = ev_scl;
            end
         end
      endcase
   end

   assign emit      = busy_ff && (wait_ff == '0) && (!rsp_valid_ff || rsp_ready);
   assign cmd_ready = !busy_ff || (emit && ev_last);
   assign load      = cmd_valid && cmd_ready;

   always_comb begin
      hold_cycles_in = csr_wr_en ? csr_wr_data : hold_cycles_ff;

      busy_in     = busy_ff;
      cur_in      = cur_ff;
      step_in     = step_ff;
      phase_in    = phase_ff;
      shift_in    = shift_ff;
      scl_line_in = scl_line_ff;
      wait_in     = (wait_ff != '0) ? wait_ff - 1'b1 : wait_ff;

      if (emit) begin
         scl_line_in = ev_scl;
         step_in     = step_ff + 1'b1;
         phase_in    = (phase_ff == i2cbs_pkg::PH_LOW) ? i2cbs_pkg::PH_SETUP
                                                       : phase_ff + 2'd1;
         if (phase_ff == i2cbs_pkg::PH_LOW) begin
            shift_in = {shift_ff[6:0], 1'b0};
         end
         if (ev_hold) begin
            wait_in = hold_cycles_ff;
         end
         if (ev_last) begin
            busy_in = 1'b0;
         end
      end

      if (load) begin
         busy_in  = 1'b1;
         cur_in   = cmd_data;
         step_in  = '0;
         phase_in = i2cbs_pkg::PH_SETUP;
         shift_in = cmd_data.data;
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_cycles_ff <= i2cbs_pkg::HOLD_RESET;
         wait_ff        <= '0;
         busy_ff        <= 1'b0;
         scl_line_ff    <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         hold_cycles_ff <= hold_cycles_in;
         wait_ff        <= wait_in;
         busy_ff        <= busy_in;
         scl_line_ff    <= scl_line_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      step_ff  <= step_in;
      phase_ff <= phase_in;
      shift_ff <= shift_in;
      if (emit) begin
         scl_ff   <= ev_scl;
         sda_ff   <= ev_sda;
         hold_ff  <= ev_hold;
         last_ff  <= ev_last;
         rdata_ff <= ev_rdata;
         ack_ff   <= ev_ack;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_scl_level  = scl_ff;
   assign rsp_sda_level  = sda_ff;
   assign rsp_hold_after = hold_ff;
   assign rsp_last       = last_ff;
   assign rsp_read_data  = rdata_ff;
   assign rsp_ack_level  = ack_ff;

endmodule

/* sv/i2c_master_bit_sequencer_core.sv */
`timescale 1ns / 1ps
// I2C master bit sequencer, top level: front end, command queue, sequencer.
// Depends on i2cbs_pkg, i2cbs_front, i2cbs_fifo and i2cbs_back.
//
// Each command beat (start, stop, write byte, read byte) becomes a run of
// result beats, one per pin event: start 4, stop 3, write 27, read 21. The
// sequencer issues at most one event per cycle; after every event marked
// hold_after it waits until a counter loaded from hold_cycles runs out
// before the next one. The held events are start 2, stop 2, write 9 and
// read 9. Commands are taken ahead through a two-entry queue, and when it
// holds one, the next command is loaded in the same cycle as the last event
// of the previous one. hold_cycles changes only timing, never a result
// field.
module i2c_master_bit_sequencer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_write_data,
   input  logic        req_send_ack,
   input  logic [7:0]  req_slave_byte,
   input  logic        req_slave_ack_level,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_scl_level,
   output logic        rsp_sda_level,
   output logic        rsp_hold_after,
   output logic        rsp_last,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_ack_level
);

   logic               front_valid, front_ready;
   i2cbs_pkg::cmd_type front_cmd;
   logic               queue_valid, queue_ready;
   i2cbs_pkg::cmd_type queue_cmd;

   i2cbs_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_write_data      (req_write_data),
      .req_send_ack        (req_send_ack),
      .req_slave_byte      (req_slave_byte),
      .req_slave_ack_level (req_slave_ack_level),
      .cmd_valid           (front_valid),
      .cmd_ready           (front_ready),
      .cmd_data            (front_cmd)
   );

   i2cbs_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_cmd),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_data   (queue_cmd)
   );

   i2cbs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .cmd_valid      (queue_valid),
      .cmd_ready      (queue_ready),
      .cmd_data       (queue_cmd),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_scl_level  (rsp_scl_level),
      .rsp_sda_level  (rsp_sda_level),
      .rsp_hold_after (rsp_hold_after),
      .rsp_last       (rsp_last),
      .rsp_read_data  (rsp_read_data),
      .rsp_ack_level  (rsp_ack_level)
   );

endmodule
